@@ sv/pid_balance_controller_assert.svh @@
// Assertion macros shared by the controller modules.
// Both expect i_clk and i_rst_n in the enclosing module.
`ifndef PID_BALANCE_CONTROLLER_ASSERT_SVH
`define PID_BALANCE_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define PBC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pbc: same-cycle check failed");

// next-cycle implication
`define PBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pbc: next-cycle check failed");

`endif

@@ sv/pbc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pbc_pkg;

    // gains and elapsed time share one operand width
    localparam int GAIN_W    = 16;
    localparam int MUL_STEPS = GAIN_W;

    // configuration register indexes
    localparam logic [1:0] REG_SETPOINT = 2'd0;
    localparam logic [1:0] REG_GAIN_P   = 2'd1;
    localparam logic [1:0] REG_GAIN_I   = 2'd2;
    localparam logic [1:0] REG_GAIN_D   = 2'd3;

    typedef logic [1:0] t_alu_op;

    localparam t_alu_op OP_MUL_S = 2'd0;  // multiplier operand signed
    localparam t_alu_op OP_MUL_U = 2'd1;  // multiplier operand unsigned
    localparam t_alu_op OP_DIV   = 2'd2;  // unsigned restoring division

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

endpackage

`default_nettype wire

@@ sv/pbc_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface pbc_in_if #(
    parameter int ANGLE_WIDTH = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_WIDTH-1:0] pitch_angle;
    logic        [15:0]            elapsed_ms;

    modport source (output valid, output pitch_angle, output elapsed_ms, input ready);
    modport sink   (input valid, input pitch_angle, input elapsed_ms, output ready);
endinterface

`default_nettype wire

@@ sv/pbc_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface pbc_out_if ();
    logic               valid;
    logic               ready;
    logic signed [15:0] motor_one_drive;
    logic signed [15:0] motor_two_drive;
    logic signed [15:0] motor_three_drive;
    logic               drive_saturated;

    modport source (output valid, output motor_one_drive, output motor_two_drive,
                    output motor_three_drive, output drive_saturated, input ready);
    modport sink   (input valid, input motor_one_drive, input motor_two_drive,
                    input motor_three_drive, input drive_saturated, output ready);
endinterface

`default_nettype wire

@@ sv/pbc_shift_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Shared shift-add multiplier / restoring divider, one bit per cycle.
module pbc_shift_alu #(
    parameter int UW = 50,
    parameter int NW = 34
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire pbc_pkg::t_alu_req           i_req,
    input  wire logic [UW-1:0]               i_a,
    input  wire logic [pbc_pkg::GAIN_W-1:0]  i_b,
    output logic                             o_done,
    output logic [UW-1:0]                    o_result
);
    localparam int CNTW = $clog2(NW + 1);
    localparam int RW   = pbc_pkg::GAIN_W + 1;

    logic                        r_busy;
    logic                        r_done;
    pbc_pkg::t_alu_op            r_op;
    logic [CNTW-1:0]             r_cnt;
    logic [UW-1:0]               r_acc;     // product, or remainder in low bits
    logic [UW-1:0]               r_mcand;   // multiplicand, or numerator/quotient
    logic [pbc_pkg::GAIN_W-1:0]  r_mplier;  // multiplier, or divisor

    logic [RW-1:0] w_trial;
    logic [RW-1:0] w_rem;
    logic          w_ge;
    logic          w_last;
    logic [UW-1:0] w_addend;

    always_comb begin
        w_trial  = {r_acc[RW-2:0], r_mcand[NW-1]};
        w_ge     = w_trial >= {1'b0, r_mplier};
        w_rem    = w_ge ? (w_trial - {1'b0, r_mplier}) : w_trial;
        w_last   = r_cnt == CNTW'(1);
        w_addend = r_mplier[0] ? r_mcand : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= pbc_pkg::OP_MUL_S;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_cnt  <= (i_req.op == pbc_pkg::OP_DIV) ? CNTW'(NW)
                                                        : CNTW'(pbc_pkg::MUL_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc    <= '0;
            r_mcand  <= i_a;
            r_mplier <= i_b;
        end else if (r_busy) begin
            case (r_op)
                pbc_pkg::OP_DIV: begin
                    r_acc   <= {{(UW-RW){1'b0}}, w_rem};
                    r_mcand <= {r_mcand[UW-2:0], w_ge};
                end
                pbc_pkg::OP_MUL_S: begin
                    // top multiplier bit carries negative weight
                    if (w_last) begin
                        r_acc <= r_acc - w_addend;
                    end else begin
                        r_acc <= r_acc + w_addend;
                    end
                    r_mcand  <= {r_mcand[UW-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[pbc_pkg::GAIN_W-1:1]};
                end
                default: begin
                    r_acc    <= r_acc + w_addend;
                    r_mcand  <= {r_mcand[UW-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[pbc_pkg::GAIN_W-1:1]};
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = (r_op == pbc_pkg::OP_DIV) ? {{(UW-NW){1'b0}}, r_mcand[NW-1:0]} : r_acc;

`include "pid_balance_controller_assert.svh"

    `PBC_ASSERT_SAME(a_no_start_busy, i_req.start, !r_busy)
    `PBC_ASSERT_SAME(a_done_at_end, r_done, !r_busy && (r_cnt == '0))

endmodule

`default_nettype wire

@@ sv/pid_balance_controller.sv @@
// Four 16-step multiplies and one (ANGLE_WIDTH+18)-step divide share one shift-add unit.
// Input ready only while the sequencer is idle; the divide is skipped when elapsed_ms is 0.
// A finished result waits in the output register while the next item is taken in.
// Reset (synchronous, active low): registers, integrator and previous error cleared.
`timescale 1ns / 1ps
`default_nettype none

module pid_balance_controller #(
    parameter int INTEGRATOR_WIDTH = 48,
    parameter int ANGLE_WIDTH      = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    pbc_in_if.sink                        i_pitch,
    pbc_out_if.source                     o_drive,
    input  wire logic                     i_cfg_we,
    input  wire logic [1:0]               i_cfg_index,
    input  wire logic [(ANGLE_WIDTH > 16 ? ANGLE_WIDTH : 16)-1:0] i_cfg_data
);
    localparam int AW   = ANGLE_WIDTH;
    localparam int IW   = INTEGRATOR_WIDTH;
    localparam int GW   = pbc_pkg::GAIN_W;
    localparam int FRAC = AW - 3;
    localparam int EW   = AW + 1;                   // error
    localparam int DW   = AW + 2;                   // error difference
    localparam int MW   = AW + 5;                   // 10*|error|
    localparam int UW   = AW + 34;                  // shared unit width
    localparam int NW   = AW + 18;                  // division numerator bits
    localparam int XW   = (IW > UW ? IW : UW) + 1;  // integrator update
    localparam int SW   = XW + 1;                   // final sum
    localparam int TW   = SW - FRAC;

    localparam logic [15:0] DRIVE_MAX = 16'h7FFF;
    localparam logic [15:0] DRIVE_MIN = 16'h8000;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PMUL  = 3'd1;
    localparam logic [2:0] S_IMUL1 = 3'd2;
    localparam logic [2:0] S_IMUL2 = 3'd3;
    localparam logic [2:0] S_DMUL  = 3'd4;
    localparam logic [2:0] S_DDIV  = 3'd5;
    localparam logic [2:0] S_SUM   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    // control and state
    logic [2:0]    r_state;
    logic          r_go;
    logic          r_out_valid;
    logic [AW-1:0] r_setpoint;
    logic [GW-1:0] r_gain_p;
    logic [GW-1:0] r_gain_i;
    logic [GW-1:0] r_gain_d;
    logic [IW-1:0] r_integral;
    logic [EW-1:0] r_prev_err;

    // payload
    logic [EW-1:0] r_err;
    logic [GW-1:0] r_dt;
    logic          r_big;
    logic          r_clip;
    logic [UW-1:0] r_p;
    logic [UW-1:0] r_d;
    logic [UW-1:0] r_tmp;
    logic [15:0]   r_drv;
    logic [15:0]   r_neg;
    logic [15:0]   r_one;
    logic [15:0]   r_three;
    logic          r_out_clip;

    pbc_pkg::t_alu_req w_req;
    logic [UW-1:0]     w_a;
    logic [GW-1:0]     w_b;
    logic              w_done;
    logic [UW-1:0]     w_res;

    logic [EW-1:0] w_err;
    logic [MW-1:0] w_err_ext;
    logic [MW-1:0] w_mag;
    logic [MW-1:0] w_mag10;
    logic          w_big;
    logic [DW-1:0] w_diff;
    logic [UW-1:0] w_tmp_mag;
    logic [UW-1:0] w_p;
    logic [XW-1:0] w_isum;
    logic          w_ihi;
    logic          w_ilo;
    logic [IW-1:0] w_isat;
    logic [SW-1:0] w_sum;
    logic [TW-1:0] w_sh;
    logic          w_dhi;
    logic          w_dlo;
    logic [15:0]   w_drv;
    logic          w_load;

    always_comb begin
        w_err     = {i_pitch.pitch_angle[AW-1], i_pitch.pitch_angle}
                  - {r_setpoint[AW-1], r_setpoint};
        w_err_ext = {{(MW-EW){w_err[EW-1]}}, w_err};
        w_mag     = w_err[EW-1] ? (~w_err_ext + MW'(1)) : w_err_ext;
        w_mag10   = {w_mag[MW-4:0], 3'b000} + {w_mag[MW-2:0], 1'b0};
        w_big     = w_mag10 > (MW'(3) << FRAC);

        w_diff    = {r_err[EW-1], r_err} - {r_prev_err[EW-1], r_prev_err};
        w_tmp_mag = r_tmp[UW-1] ? (~r_tmp + UW'(1)) : r_tmp;
        w_p       = r_big ? {w_res[UW-2:0], 1'b0} : w_res;

        // integrator: saturate when the bits above the sign position disagree
        w_isum = {{(XW-IW){r_integral[IW-1]}}, r_integral} + {{(XW-UW){w_res[UW-1]}}, w_res};
        w_ihi  = !w_isum[XW-1] && (|w_isum[XW-2:IW-1]);
        w_ilo  = w_isum[XW-1] && !(&w_isum[XW-2:IW-1]);
        if (w_ihi) begin
            w_isat = {1'b0, {(IW-1){1'b1}}};
        end else if (w_ilo) begin
            w_isat = {1'b1, {(IW-1){1'b0}}};
        end else begin
            w_isat = w_isum[IW-1:0];
        end

        // floor shift is a part-select of the two's complement sum
        w_sum = {{(SW-UW){r_p[UW-1]}}, r_p} + {{(SW-UW){r_d[UW-1]}}, r_d}
              + {{(SW-IW){r_integral[IW-1]}}, r_integral};
        w_sh  = w_sum[SW-1:FRAC];
        w_dhi = !w_sh[TW-1] && (|w_sh[TW-2:15]);
        w_dlo = w_sh[TW-1] && !(&w_sh[TW-2:15]);
        if (w_dhi) begin
            w_drv = DRIVE_MAX;
        end else if (w_dlo) begin
            w_drv = DRIVE_MIN;
        end else begin
            w_drv = w_sh[15:0];
        end

        w_load = (r_state == S_OUT) && (!r_out_valid || o_drive.ready);
    end

    // operand selection for the shared unit
    always_comb begin
        w_req.start = r_go;
        w_req.op    = pbc_pkg::OP_MUL_S;
        w_a         = {{(UW-EW){r_err[EW-1]}}, r_err};
        w_b         = r_gain_p;
        case (r_state)
            S_IMUL1: w_b = r_gain_i;
            S_IMUL2: begin
                w_req.op = pbc_pkg::OP_MUL_U;
                w_a      = r_tmp;
                w_b      = r_dt;
            end
            S_DMUL: begin
                w_a = {{(UW-DW){w_diff[DW-1]}}, w_diff};
                w_b = r_gain_d;
            end
            S_DDIV: begin
                w_req.op = pbc_pkg::OP_DIV;
                w_a      = w_tmp_mag;
                w_b      = r_dt;
            end
            default: begin
                w_b = r_gain_p;
            end
        endcase
    end

    pbc_shift_alu #(
        .UW (UW),
        .NW (NW)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_a      (w_a),
        .i_b      (w_b),
        .o_done   (w_done),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
            r_setpoint  <= '0;
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_integral  <= '0;
            r_prev_err  <= '0;
        end else begin
            r_go <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pbc_pkg::REG_SETPOINT: r_setpoint <= i_cfg_data[AW-1:0];
                    pbc_pkg::REG_GAIN_P:   r_gain_p   <= i_cfg_data[GW-1:0];
                    pbc_pkg::REG_GAIN_I:   r_gain_i   <= i_cfg_data[GW-1:0];
                    pbc_pkg::REG_GAIN_D:   r_gain_d   <= i_cfg_data[GW-1:0];
                    default:               r_gain_d   <= r_gain_d;
                endcase
            end
            if (r_out_valid && o_drive.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: if (i_pitch.valid) begin
                    r_state <= S_PMUL;
                    r_go    <= 1'b1;
                end
                S_PMUL: if (w_done) begin
                    r_state <= S_IMUL1;
                    r_go    <= 1'b1;
                end
                S_IMUL1: if (w_done) begin
                    r_state <= S_IMUL2;
                    r_go    <= 1'b1;
                end
                S_IMUL2: if (w_done) begin
                    r_integral <= w_isat;
                    r_state    <= S_DMUL;
                    r_go       <= 1'b1;
                end
                S_DMUL: if (w_done) begin
                    r_prev_err <= r_err;
                    // no elapsed time: derivative stays zero, skip the divide
                    if (r_dt == '0) begin
                        r_state <= S_SUM;
                    end else begin
                        r_state <= S_DDIV;
                        r_go    <= 1'b1;
                    end
                end
                S_DDIV: if (w_done) begin
                    r_state <= S_SUM;
                end
                S_SUM: r_state <= S_OUT;
                S_OUT: if (w_load) begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (i_pitch.valid) begin
                r_err  <= w_err;
                r_dt   <= i_pitch.elapsed_ms;
                r_big  <= w_big;
                r_clip <= 1'b0;
            end
            S_PMUL: if (w_done) begin
                r_p <= w_p;
            end
            S_IMUL1: if (w_done) begin
                r_tmp <= w_res;
            end
            S_IMUL2: if (w_done) begin
                r_clip <= r_clip | w_ihi | w_ilo;
            end
            S_DMUL: if (w_done) begin
                r_tmp <= w_res;
                r_d   <= '0;
            end
            S_DDIV: if (w_done) begin
                // quotient takes the numerator's sign: truncation toward zero
                r_d <= r_tmp[UW-1] ? (~w_res + UW'(1)) : w_res;
            end
            S_SUM: begin
                r_drv  <= w_drv;
                r_neg  <= (w_drv == DRIVE_MIN) ? DRIVE_MAX : (~w_drv + 16'd1);
                r_clip <= r_clip | w_dhi | w_dlo | (w_drv == DRIVE_MIN);
            end
            S_OUT: if (w_load) begin
                r_one      <= r_drv;
                r_three    <= r_neg;
                r_out_clip <= r_clip;
            end
            default: r_clip <= r_clip;
        endcase
    end

    assign i_pitch.ready             = (r_state == S_IDLE);
    assign o_drive.valid             = r_out_valid;
    assign o_drive.motor_one_drive   = r_one;
    assign o_drive.motor_two_drive   = r_one;
    assign o_drive.motor_three_drive = r_three;
    assign o_drive.drive_saturated   = r_out_clip;

`include "pid_balance_controller_assert.svh"

    `PBC_ASSERT_SAME(a_motor_mirror, r_out_valid && !r_out_clip, r_three == (~r_one + 16'd1))
    `PBC_ASSERT_NEXT(a_out_hold, (r_state == S_OUT) && r_out_valid && !o_drive.ready, r_state == S_OUT)

endmodule

`default_nettype wire

@@ verif/pid_balance_controller_tb.sv @@
`timescale 1ns / 1ps

module pid_balance_controller_tb;

    localparam int ANGLE_W     = 16;
    localparam int INTEG_W     = 48;
    localparam int FRAC        = ANGLE_W - 3;
    localparam int LATENCY     = ANGLE_W + 94;
    localparam int CYCLE_LIMIT = 600000;

    localparam int NUM_SETTINGS        = 8;
    localparam int SAMPLES_PER_SETTING = 100;
    localparam int QUIET_FIRST         = 350;
    localparam int QUIET_LAST          = 500;
    localparam int SHOWN_FAILURES      = 10;

    localparam longint INTEG_MAX = (64'sd1 <<< (INTEG_W - 1)) - 64'sd1;
    localparam longint INTEG_MIN = -INTEG_MAX - 64'sd1;

    typedef struct packed {
        logic signed [15:0] m1;
        logic signed [15:0] m2;
        logic signed [15:0] m3;
        logic               sat;
    } t_drive;

    typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_TYPED} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  index;
        logic [15:0] data;
        logic [15:0] pitch;
        logic [15:0] dt;
        t_drive      drive;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    pbc_in_if #(.ANGLE_WIDTH(ANGLE_W)) pitch_if ();
    pbc_out_if drive_if ();

    pid_balance_controller #(
        .INTEGRATOR_WIDTH(INTEG_W),
        .ANGLE_WIDTH     (ANGLE_W)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pitch    (pitch_if),
        .o_drive    (drive_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    // controller copy: registers and state
    longint setpoint_q;
    longint kp_q;
    longint ki_q;
    longint kd_q;
    longint integ_q;
    longint prev_err_q;

    t_drive pending_drive_q[$];
    t_row   rows[$];

    int     cycles;
    int     failures;
    int     samples_sent;
    int     writes_done;
    int     drives_checked;
    int     drives_clipped;
    t_drive seen_drive;
    t_drive want_drive;

    wire calm = (samples_sent >= QUIET_FIRST) && (samples_sent < QUIET_LAST);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("pid_balance_controller_tb NOT OK");
            $finish;
        end
    end

    function automatic t_drive predict_drive(logic signed [15:0] pitch, logic [15:0] dt);
        longint err;
        longint mag;
        longint p;
        longint d;
        longint inc;
        longint acc;
        longint drv;
        longint neg;
        longint dtl;
        logic   clip;
        t_drive r;
        dtl  = longint'(dt);
        err  = longint'(pitch) - setpoint_q;
        mag  = (err < 0) ? -err : err;
        clip = 1'b0;
        p = kp_q * err;
        // large error: proportional term doubled
        if (mag * 10 > (longint'(3) <<< FRAC))
            p = p * 2;
        inc = ki_q * err * dtl;
        if (inc > 0 && integ_q > INTEG_MAX - inc) begin
            integ_q = INTEG_MAX;
            clip    = 1'b1;
        end else if (inc < 0 && integ_q < INTEG_MIN - inc) begin
            integ_q = INTEG_MIN;
            clip    = 1'b1;
        end else begin
            integ_q = integ_q + inc;
        end
        d   = (dtl != 0) ? (kd_q * (err - prev_err_q)) / dtl : 64'sd0;
        acc = p + d + integ_q;    // cannot leave 64 bits at these widths
        drv = acc >>> FRAC;
        if (drv > 32767) begin
            drv  = 32767;
            clip = 1'b1;
        end
        if (drv < -32768) begin
            drv  = -32768;
            clip = 1'b1;
        end
        neg = -drv;
        if (neg > 32767) begin
            neg  = 32767;
            clip = 1'b1;
        end
        prev_err_q = err;
        r.m1  = drv[15:0];
        r.m2  = drv[15:0];
        r.m3  = neg[15:0];
        r.sat = clip;
        return r;
    endfunction

    function automatic logic [15:0] pick_reg_value(int spread);
        int offset;
        offset = int'($urandom_range(0, 2 * spread)) - spread;
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom);
            default: return offset[15:0];
        endcase
    endfunction

    task automatic note_failure(string msg);
        failures++;
        if (failures <= SHOWN_FAILURES)
            $display("%s", msg);
    endtask

    task automatic write_reg(logic [1:0] index, logic [15:0] data);
        @(negedge i_clk) pitch_if.valid = 1'b0;
        while (pending_drive_q.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(negedge i_clk) cfg_we = 1'b0;
        case (index)
            pbc_pkg::REG_SETPOINT: setpoint_q = longint'($signed(data));
            pbc_pkg::REG_GAIN_P:   kp_q       = longint'($signed(data));
            pbc_pkg::REG_GAIN_I:   ki_q       = longint'($signed(data));
            pbc_pkg::REG_GAIN_D:   kd_q       = longint'($signed(data));
            default:               ;
        endcase
        writes_done++;
    endtask

    task automatic send_sample(logic signed [15:0] pitch, logic [15:0] dt, logic typed,
                               t_drive typed_drive);
        t_drive predicted;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 99) < 20) begin
            pitch_if.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        pitch_if.valid       = 1'b1;
        pitch_if.pitch_angle = pitch;
        pitch_if.elapsed_ms  = dt;
        do @(posedge i_clk); while (!pitch_if.ready);
        predicted = predict_drive(pitch, dt);
        pending_drive_q.push_back(typed ? typed_drive : predicted);
        samples_sent++;
    endtask

    task automatic add_write(logic [1:0] index, logic [15:0] data);
        t_row r;
        r       = '0;
        r.kind  = ROW_WRITE;
        r.index = index;
        r.data  = data;
        rows.push_back(r);
    endtask

    task automatic add_sample(logic [15:0] pitch, logic [15:0] dt);
        t_row r;
        r       = '0;
        r.kind  = ROW_SAMPLE;
        r.pitch = pitch;
        r.dt    = dt;
        rows.push_back(r);
    endtask

    task automatic add_typed(logic [15:0] pitch, logic [15:0] dt, int drv, int neg, logic sat);
        t_row r;
        r           = '0;
        r.kind      = ROW_TYPED;
        r.pitch     = pitch;
        r.dt        = dt;
        r.drive.m1  = drv[15:0];
        r.drive.m2  = drv[15:0];
        r.drive.m3  = neg[15:0];
        r.drive.sat = sat;
        rows.push_back(r);
    endtask

    task automatic build_table();
        // all gains zero after reset
        add_typed(16'h7fff, 16'hffff, 0, 0, 1'b0);
        add_typed(16'h8000, 16'h0000, 0, 0, 1'b0);
        add_write(pbc_pkg::REG_GAIN_P, 16'd256);
        add_typed(16'd8192, 16'd1, 512, -512, 1'b0);
        add_typed(16'd2000, 16'd1, 62, -62, 1'b0);
        add_typed(-16'sd2000, 16'd1, -63, 63, 1'b0);    // floor on the final shift
        // either side of the doubling threshold
        add_sample(16'd2457, 16'd5);
        add_sample(16'd2458, 16'd5);
        add_sample(-16'sd2458, 16'd5);
        add_write(pbc_pkg::REG_SETPOINT, 16'h8000);
        add_write(pbc_pkg::REG_GAIN_P, 16'h7fff);
        add_typed(16'h7fff, 16'd1, 32767, -32767, 1'b1);
        add_typed(16'h8000, 16'd1, 0, 0, 1'b0);
        add_write(pbc_pkg::REG_GAIN_P, 16'h8000);
        add_write(pbc_pkg::REG_SETPOINT, 16'h7fff);
        add_typed(16'h8000, 16'd1, 32767, -32767, 1'b1);
        // drive lands on -32768 exactly: only the negation clips
        add_write(pbc_pkg::REG_SETPOINT, 16'h0000);
        add_typed(16'd4096, 16'd1, -32768, 32767, 1'b1);
        // derivative, with truncation and zero elapsed time
        add_write(pbc_pkg::REG_GAIN_P, 16'h0000);
        add_write(pbc_pkg::REG_GAIN_D, 16'd256);
        add_sample(16'd1001, 16'd3);
        add_sample(16'd0, 16'd0);
        add_write(pbc_pkg::REG_GAIN_D, 16'h7fff);
        add_sample(16'h7fff, 16'd1);
        add_sample(16'h8000, 16'hffff);
        add_sample(16'd500, 16'd2);
        // integrator driven into both bounds
        add_write(pbc_pkg::REG_GAIN_D, 16'h0000);
        add_write(pbc_pkg::REG_GAIN_I, 16'h7fff);
        add_write(pbc_pkg::REG_SETPOINT, 16'h8000);
        add_sample(16'h7fff, 16'hffff);
        add_sample(16'h7fff, 16'hffff);
        add_write(pbc_pkg::REG_SETPOINT, 16'h7fff);
        add_sample(16'h8000, 16'hffff);
        add_sample(16'h8000, 16'hffff);
        add_sample(16'h8000, 16'hffff);
        add_sample(16'd0, 16'd0);
    endtask

    initial begin
        drive_if.ready = 1'b0;
        forever @(negedge i_clk)
            drive_if.ready <= calm || ($urandom_range(0, 99) >= 20);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && drive_if.valid && drive_if.ready) begin
            seen_drive.m1  = drive_if.motor_one_drive;
            seen_drive.m2  = drive_if.motor_two_drive;
            seen_drive.m3  = drive_if.motor_three_drive;
            seen_drive.sat = drive_if.drive_saturated;
            drives_checked++;
            if (pending_drive_q.size() == 0) begin
                note_failure($sformatf("drive %0d: no result was due, got %0d/%0d/%0d sat %0b",
                    drives_checked, seen_drive.m1, seen_drive.m2, seen_drive.m3,
                    seen_drive.sat));
            end else begin
                want_drive = pending_drive_q.pop_front();
                if (want_drive.sat)
                    drives_clipped++;
                if (seen_drive.m1 !== want_drive.m1 || seen_drive.m2 !== want_drive.m2 ||
                    seen_drive.m3 !== want_drive.m3 || seen_drive.sat !== want_drive.sat) begin
                    note_failure($sformatf(
                        "drive %0d: expected %0d/%0d/%0d sat %0b, got %0d/%0d/%0d sat %0b",
                        drives_checked, want_drive.m1, want_drive.m2, want_drive.m3,
                        want_drive.sat, seen_drive.m1, seen_drive.m2, seen_drive.m3,
                        seen_drive.sat));
                end
            end
        end
    end

    initial begin
        int                 setting;
        int                 n;
        int                 offset;
        logic signed [15:0] pitch;
        logic        [15:0] dt;
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = pbc_pkg::REG_SETPOINT;
        cfg_data             = '0;
        pitch_if.valid       = 1'b0;
        pitch_if.pitch_angle = '0;
        pitch_if.elapsed_ms  = '0;
        setpoint_q = 0;
        kp_q       = 0;
        ki_q       = 0;
        kd_q       = 0;
        integ_q    = 0;
        prev_err_q = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        build_table();
        foreach (rows[k]) begin
            if (rows[k].kind == ROW_WRITE)
                write_reg(rows[k].index, rows[k].data);
            else
                send_sample(rows[k].pitch, rows[k].dt, rows[k].kind == ROW_TYPED,
                            rows[k].drive);
        end

        // first two settings pin every register at an extreme
        for (setting = 0; setting < NUM_SETTINGS; setting++) begin
            write_reg(pbc_pkg::REG_SETPOINT, (setting == 0) ? 16'h7fff :
                                             (setting == 1) ? 16'h8000 : pick_reg_value(8192));
            write_reg(pbc_pkg::REG_GAIN_P, (setting == 0) ? 16'h7fff :
                                           (setting == 1) ? 16'h8000 : pick_reg_value(512));
            write_reg(pbc_pkg::REG_GAIN_I, (setting == 0) ? 16'h7fff :
                                           (setting == 1) ? 16'h8000 : pick_reg_value(32));
            write_reg(pbc_pkg::REG_GAIN_D, (setting == 0) ? 16'h7fff :
                                           (setting == 1) ? 16'h8000 : pick_reg_value(2048));
            for (n = 0; n < SAMPLES_PER_SETTING; n++) begin
                offset = int'($urandom_range(0, 8000)) - 4000;
                case ($urandom_range(0, 9))
                    0:       pitch = 16'sh7fff;
                    1:       pitch = 16'sh8000;
                    2, 3:    pitch = 16'($urandom);
                    default: pitch = setpoint_q[15:0] + offset[15:0];
                endcase
                case ($urandom_range(0, 9))
                    0:       dt = 16'h0000;
                    1:       dt = 16'hffff;
                    2:       dt = 16'($urandom);
                    default: dt = 16'($urandom_range(1, 20));
                endcase
                send_sample(pitch, dt, 1'b0, '0);
            end
        end

        @(negedge i_clk) pitch_if.valid = 1'b0;
        while (pending_drive_q.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);

        $display("%0d pitch samples over %0d register writes, directed extremes then random",
                 samples_sent, writes_done);
        $display("%0d drive results checked, %0d of them clipped", drives_checked,
                 drives_clipped);
        if (failures == 0)
            $display("pid_balance_controller_tb OK");
        else
            $display("pid_balance_controller_tb NOT OK");
        $finish;
    end

endmodule
